/* src/winograd_f4x3_input_transform_core_macros.svh */
// assertion macros for the winograd input transform core
`ifndef WINOGRAD_F4X3_INPUT_TRANSFORM_CORE_MACROS_SVH
`define WINOGRAD_F4X3_INPUT_TRANSFORM_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define WGIT_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");
`define WGIT_ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define WGIT_ASSERT_IMP(label, clk, rst, pre, post)
`define WGIT_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

/* src/wgit_pkg.sv */
// types, constants and scaling functions of the winograd input transform
package wgit_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TILE_DIM    = 6;
  localparam int COEF_W      = 23;
  localparam int SUM_W       = SAMPLE_BITS + 4;
  localparam int RES_W       = SAMPLE_BITS + 7;
  localparam int WORK_W      = (RES_W > COEF_W) ? RES_W : COEF_W;
  localparam int ROW_W       = $clog2(TILE_DIM);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic signed [WORK_W-1:0]      work_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [3:0]             bt_t;
  typedef logic [ROW_W-1:0]              row_idx_t;

  typedef sum_t sum_tile_t [TILE_DIM][TILE_DIM];

  localparam row_idx_t LAST_ROW = ROW_W'(TILE_DIM - 1);

  // transposed input transform matrix
  localparam bt_t BT [TILE_DIM][TILE_DIM] = '{
    '{ 4'sd4,  4'sd0, -4'sd5,  4'sd0, 4'sd1, 4'sd0},
    '{ 4'sd0, -4'sd4, -4'sd4,  4'sd1, 4'sd1, 4'sd0},
    '{ 4'sd0,  4'sd4, -4'sd4, -4'sd1, 4'sd1, 4'sd0},
    '{ 4'sd0, -4'sd2, -4'sd1,  4'sd2, 4'sd1, 4'sd0},
    '{ 4'sd0,  4'sd2, -4'sd1, -4'sd2, 4'sd1, 4'sd0},
    '{ 4'sd0,  4'sd4,  4'sd0, -4'sd5, 4'sd0, 4'sd1}
  };

  // sample times matrix entry, shifts and adds only
  function automatic sum_t scale_sample(sample_t x, bt_t c);
    sum_t xe;
    sum_t r;
    xe = SUM_W'(x);
    case (c)
      4'sd1:   r = xe;
      -4'sd1:  r = -xe;
      4'sd2:   r = xe <<< 1;
      -4'sd2:  r = -(xe <<< 1);
      4'sd4:   r = xe <<< 2;
      -4'sd4:  r = -(xe <<< 2);
      -4'sd5:  r = -((xe <<< 2) + xe);
      default: r = '0;
    endcase
    return r;
  endfunction

  // column-pass sum times matrix entry
  function automatic work_t scale_sum(sum_t x, bt_t c);
    work_t xe;
    work_t r;
    xe = WORK_W'(x);
    case (c)
      4'sd1:   r = xe;
      -4'sd1:  r = -xe;
      4'sd2:   r = xe <<< 1;
      -4'sd2:  r = -(xe <<< 1);
      4'sd4:   r = xe <<< 2;
      -4'sd4:  r = -(xe <<< 2);
      -4'sd5:  r = -((xe <<< 2) + xe);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* src/wgit_if.sv */
// valid/ready channel interfaces for tile rows in and transformed rows out
interface wgit_in_if import wgit_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample0;
  sample_t sample1;
  sample_t sample2;
  sample_t sample3;
  sample_t sample4;
  sample_t sample5;

  modport source (output valid, output sample0, output sample1, output sample2,
                  output sample3, output sample4, output sample5, input ready);
  modport sink   (input valid, input sample0, input sample1, input sample2,
                  input sample3, input sample4, input sample5, output ready);
endinterface

interface wgit_out_if import wgit_pkg::*; ();
  logic     valid;
  logic     ready;
  row_idx_t out_row;
  coef_t    coef0;
  coef_t    coef1;
  coef_t    coef2;
  coef_t    coef3;
  coef_t    coef4;
  coef_t    coef5;
  logic     last_row;

  modport source (output valid, output out_row, output coef0, output coef1,
                  output coef2, output coef3, output coef4, output coef5,
                  output last_row, input ready);
  modport sink   (input valid, input out_row, input coef0, input coef1,
                  input coef2, input coef3, input coef4, input coef5,
                  input last_row, output ready);
endinterface

/* src/winograd_f4x3_input_transform_core.sv */
// top level of the winograd F(4x4,3x3) input transform core
//
//  channel   dir  transaction              fields
//  tile_in   in   one 6-sample tile row    sample0..sample5 (16b signed)
//  coef_out  out  one transformed row      out_row, coef0..coef5 (23b signed), last_row
//
// a tile row is taken every cycle in steady state: six rows in, then the
// column-pass result moves to a tile bank and the next tile accumulates while
// the bank drains one output row per cycle through the output register
// a finished tile passes from the input register through the bank to the output register
// the sixth row of a tile waits in the input register until the bank is free
// rst is synchronous and clears the accumulator, row counts and valid flags
// coef_out stalls hold the output register and the bank, and a long stall
// reaches tile_in.ready through the waiting sixth row
module winograd_f4x3_input_transform_core import wgit_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  wgit_in_if.sink    tile_in,
  wgit_out_if.source coef_out
);

  // handoff between column pass and row pass
  logic      tile_load;
  logic      bank_busy;
  sum_tile_t tile_data;

  // B^T applied row by row as rows arrive
  wgit_column_pass u_column_pass (
    .clk       (clk),
    .rst       (rst),
    .tile_in   (tile_in),
    .bank_busy (bank_busy),
    .tile_load (tile_load),
    .tile_data (tile_data)
  );

  // times B, one result row per cycle while coef_out is ready
  wgit_row_pass u_row_pass (
    .clk       (clk),
    .rst       (rst),
    .tile_load (tile_load),
    .tile_data (tile_data),
    .bank_busy (bank_busy),
    .coef_out  (coef_out)
  );

endmodule

/* src/wgit_column_pass.sv */
// input row register and 6x6 column-pass accumulator
module wgit_column_pass import wgit_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  wgit_in_if.sink   tile_in,
  input  logic      bank_busy,
  output logic      tile_load,
  output sum_tile_t tile_data
);

  logic      row_v;
  sample_t   row_q [TILE_DIM];
  row_idx_t  rows_taken;
  sum_tile_t sums;
  logic      adv;

  assign adv       = row_v && ((rows_taken != LAST_ROW) || !bank_busy);
  assign tile_load = row_v && (rows_taken == LAST_ROW) && !bank_busy;
  assign tile_in.ready = !row_v || adv;

  always_comb begin
    for (int i = 0; i < TILE_DIM; i++) begin
      for (int j = 0; j < TILE_DIM; j++) begin
        tile_data[i][j] = sums[i][j] + scale_sample(row_q[j], BT[i][rows_taken]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tile_in.valid && tile_in.ready) begin
      row_q[0] <= tile_in.sample0;
      row_q[1] <= tile_in.sample1;
      row_q[2] <= tile_in.sample2;
      row_q[3] <= tile_in.sample3;
      row_q[4] <= tile_in.sample4;
      row_q[5] <= tile_in.sample5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_v      <= 1'b0;
      rows_taken <= '0;
      for (int i = 0; i < TILE_DIM; i++) begin
        for (int j = 0; j < TILE_DIM; j++) begin
          sums[i][j] <= '0;
        end
      end
    end else begin
      if (tile_in.ready) begin
        row_v <= tile_in.valid;
      end
      if (adv) begin
        if (tile_load) begin
          rows_taken <= '0;
          for (int i = 0; i < TILE_DIM; i++) begin
            for (int j = 0; j < TILE_DIM; j++) begin
              sums[i][j] <= '0;
            end
          end
        end else begin
          rows_taken <= rows_taken + 1'b1;
          sums       <= tile_data;
        end
      end
    end
  end

endmodule

/* src/wgit_row_pass.sv */
// tile bank, row sequencer and row-pass output register
`include "winograd_f4x3_input_transform_core_macros.svh"
module wgit_row_pass import wgit_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      tile_load,
  input  sum_tile_t tile_data,
  output logic      bank_busy,
  wgit_out_if.source coef_out
);

  sum_tile_t bank;
  logic      bank_full;
  row_idx_t  emit_row;
  logic      issue;
  logic      issue_last;
  work_t     acc [TILE_DIM];

  logic      out_v;
  row_idx_t  out_row_q;
  logic      last_q;
  coef_t     coef_q [TILE_DIM];

  assign issue      = bank_full && (!out_v || coef_out.ready);
  assign issue_last = issue && (emit_row == LAST_ROW);
  // bank frees up in the cycle its last row goes to the output register
  assign bank_busy  = bank_full && !issue_last;

  always_comb begin
    for (int j = 0; j < TILE_DIM; j++) begin
      acc[j] = '0;
      for (int c = 0; c < TILE_DIM; c++) begin
        acc[j] = acc[j] + scale_sum(bank[emit_row][c], BT[j][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tile_load) begin
      bank <= tile_data;
    end
    if (issue) begin
      out_row_q <= emit_row;
      last_q    <= (emit_row == LAST_ROW);
      for (int j = 0; j < TILE_DIM; j++) begin
        coef_q[j] <= acc[j][COEF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_full <= 1'b0;
      emit_row  <= '0;
      out_v     <= 1'b0;
    end else begin
      if (issue) begin
        out_v <= 1'b1;
      end else if (coef_out.ready) begin
        out_v <= 1'b0;
      end
      if (tile_load) begin
        bank_full <= 1'b1;
        emit_row  <= '0;
      end else if (issue_last) begin
        bank_full <= 1'b0;
        emit_row  <= '0;
      end else if (issue) begin
        emit_row  <= emit_row + 1'b1;
      end
    end
  end

  assign coef_out.valid    = out_v;
  assign coef_out.out_row  = out_row_q;
  assign coef_out.last_row = last_q;
  assign coef_out.coef0    = coef_q[0];
  assign coef_out.coef1    = coef_q[1];
  assign coef_out.coef2    = coef_q[2];
  assign coef_out.coef3    = coef_q[3];
  assign coef_out.coef4    = coef_q[4];
  assign coef_out.coef5    = coef_q[5];

  `WGIT_ASSERT_IMP(rp_load_free, clk, rst, tile_load, !bank_full || issue_last)
  `WGIT_ASSERT_IMP(rp_row_held, clk, rst, emit_row != '0, bank_full)
  `WGIT_ASSERT_NXT(rp_last_mark, clk, rst, issue_last,
                   out_v && last_q && (out_row_q == LAST_ROW))

endmodule

/* tb/sv/tb_winograd_f4x3_input_transform_core.sv */
// self-checking testbench for the winograd F(4x4,3x3) input transform core
`timescale 1ns / 1ps

module tb_winograd_f4x3_input_transform_core;
  import wgit_pkg::*;

  // one tile row as offered on tile_in, one transformed row as seen on coef_out
  typedef sample_t [5:0] tile_row_t;
  typedef struct packed {
    row_idx_t      out_row;
    coef_t   [5:0] coef;
    logic          last_row;
  } xform_row_t;

  // B^T, kept locally so the prediction does not lean on the design's tables
  localparam int XFORM_BT [6][6] = '{
    '{4,  0, -5,  0, 1, 0},
    '{0, -4, -4,  1, 1, 0},
    '{0,  4, -4, -1, 1, 0},
    '{0, -2, -1,  2, 1, 0},
    '{0,  2, -1, -2, 1, 0},
    '{0,  4,  0, -5, 0, 1}
  };

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wgit_in_if  tile_in ();
  wgit_out_if coef_out ();

  winograd_f4x3_input_transform_core dut (
    .clk      (clk),
    .rst      (rst),
    .tile_in  (tile_in),
    .coef_out (coef_out)
  );

  always #4 clk = ~clk;

  // rows waiting to be offered, and transformed rows the core still owes us
  tile_row_t  pending_rows[$];
  xform_row_t owed_rows[$];

  // predictor state: column-pass sums (B^T d) and how many rows of the tile are in
  longint col_sums [6][6];
  int     tile_rows_in;

  int     err_count;
  int     rows_accepted;
  int     total_rows;
  logic   long_hold;

  // mismatch bookkeeping: every failure counts, only the first few are printed
  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // fold one accepted tile row into the column pass; on the sixth row apply the
  // row pass and queue the six transformed rows
  task automatic transform_row(input tile_row_t row);
    longint     acc;
    xform_row_t res;
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 6; j++) begin
        col_sums[i][j] += longint'(XFORM_BT[i][tile_rows_in]) * longint'($signed(row[j]));
      end
    end
    tile_rows_in++;
    if (tile_rows_in == 6) begin
      for (int i = 0; i < 6; i++) begin
        res.out_row  = row_idx_t'(i);
        res.last_row = (i == 5);
        for (int j = 0; j < 6; j++) begin
          acc = 0;
          for (int c = 0; c < 6; c++) begin
            acc += longint'(XFORM_BT[j][c]) * col_sums[i][c];
          end
          // results are emitted as the low 23 bits
          res.coef[j] = acc[COEF_W-1:0];
        end
        owed_rows.push_back(res);
      end
      for (int i = 0; i < 6; i++) begin
        for (int j = 0; j < 6; j++) begin
          col_sums[i][j] = 0;
        end
      end
      tile_rows_in = 0;
    end
  endtask

  // compare the transaction on coef_out with the oldest owed row, field by field
  task automatic check_xform_row();
    xform_row_t want;
    coef_t      got [6];
    got[0] = coef_out.coef0;
    got[1] = coef_out.coef1;
    got[2] = coef_out.coef2;
    got[3] = coef_out.coef3;
    got[4] = coef_out.coef4;
    got[5] = coef_out.coef5;
    if (owed_rows.size() == 0) begin
      report_mismatch($sformatf("row %0d arrived with nothing owed", coef_out.out_row));
      return;
    end
    want = owed_rows.pop_front();
    if (coef_out.out_row !== want.out_row) begin
      report_mismatch($sformatf("out_row got %0d want %0d", coef_out.out_row, want.out_row));
    end
    for (int j = 0; j < 6; j++) begin
      if (got[j] !== want.coef[j]) begin
        report_mismatch($sformatf("row %0d coef%0d got %0d want %0d", want.out_row, j,
                                  $signed(got[j]), $signed(want.coef[j])));
      end
    end
    if (coef_out.last_row !== want.last_row) begin
      report_mismatch($sformatf("row %0d last_row got %b want %b", want.out_row,
                                coef_out.last_row, want.last_row));
    end
  endtask

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 85) return $urandom_range(1, 3);
    else if (roll < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 45);
  endfunction

  // sample values lean on the extremes and on small numbers around zero
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(SAMPLE_MAX);
      1:       return sample_t'(SAMPLE_MIN);
      2:       return sample_t'($urandom_range(0, 8) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // source side: present rows from the pending queue, with random idle cycles;
  // a row is held until the core takes it
  int unsigned src_gap;
  logic        src_free;
  tile_row_t   held_row;

  always @(posedge clk) begin : source_drive
    logic next_valid;
    if (rst) begin
      tile_in.valid <= 1'b0;
      src_gap  = 0;
      src_free = 1'b0;
    end else begin
      if (tile_in.valid && tile_in.ready) begin
        transform_row(held_row);
        rows_accepted++;
      end
      // a row not yet taken stays on the bus untouched
      if (!(tile_in.valid && !tile_in.ready)) begin
        next_valid = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_rows.size() > 0) begin
          held_row   = pending_rows.pop_front();
          next_valid = 1'b1;
          tile_in.sample0 <= held_row[0];
          tile_in.sample1 <= held_row[1];
          tile_in.sample2 <= held_row[2];
          tile_in.sample3 <= held_row[3];
          tile_in.sample4 <= held_row[4];
          tile_in.sample5 <= held_row[5];
          // flip between back-to-back stretches and gappy stretches now and then
          if ($urandom_range(0, 23) == 0) src_free = !src_free;
          src_gap = src_free ? 0 : pick_gap();
        end
        tile_in.valid <= next_valid;
      end
    end
  end

  // sink side: check every transaction, stall at random, and stay stalled
  // while the long hold-off is on
  int unsigned snk_gap;
  logic        snk_free;

  always @(posedge clk) begin : sink_drive
    logic next_ready;
    if (rst) begin
      coef_out.ready <= 1'b0;
      snk_gap  = 0;
      snk_free = 1'b0;
    end else begin
      if (coef_out.valid && coef_out.ready) begin
        check_xform_row();
      end
      if (long_hold) begin
        next_ready = 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        next_ready = 1'b0;
      end else begin
        if ($urandom_range(0, 31) == 0) snk_free = !snk_free;
        snk_gap    = snk_free ? 0 : pick_gap();
        next_ready = (snk_gap == 0);
        if (snk_gap > 0) snk_gap--;
      end
      coef_out.ready <= next_ready;
    end
  end

  // back-pressure: once a few tiles are through, refuse output for a long
  // stretch while the source keeps offering rows, so the core fills and
  // drops tile_in.ready
  initial begin
    long_hold = 1'b0;
    while (rows_accepted < 48) @(posedge clk);
    long_hold <= 1'b1;
    repeat (90) @(posedge clk);
    long_hold <= 1'b0;
  end

  // run limit, far beyond the slowest legal run of this stimulus
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus build, reset, and end of run
  initial begin
    tile_row_t row;
    tile_in.valid   = 1'b0;
    tile_in.sample0 = '0;
    tile_in.sample1 = '0;
    tile_in.sample2 = '0;
    tile_in.sample3 = '0;
    tile_in.sample4 = '0;
    tile_in.sample5 = '0;
    coef_out.ready  = 1'b0;
    err_count     = 0;
    rows_accepted = 0;
    tile_rows_in  = 0;
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 6; j++) begin
        col_sums[i][j] = 0;
      end
    end

    // directed tiles: all zero, all most positive, all most negative
    for (int r = 0; r < 6; r++) begin
      for (int c = 0; c < 6; c++) row[c] = '0;
      pending_rows.push_back(row);
    end
    for (int r = 0; r < 6; r++) begin
      for (int c = 0; c < 6; c++) row[c] = sample_t'(SAMPLE_MAX);
      pending_rows.push_back(row);
    end
    for (int r = 0; r < 6; r++) begin
      for (int c = 0; c < 6; c++) row[c] = sample_t'(SAMPLE_MIN);
      pending_rows.push_back(row);
    end
    // extremes signed to line up with the coefficients: drives the corner
    // result close to its full range
    for (int r = 0; r < 6; r++) begin
      for (int c = 0; c < 6; c++) begin
        row[c] = (XFORM_BT[0][r] * XFORM_BT[0][c] >= 0) ? sample_t'(SAMPLE_MAX)
                                                         : sample_t'(SAMPLE_MIN);
      end
      pending_rows.push_back(row);
    end

    // random tiles
    for (int t = 0; t < 23; t++) begin
      for (int r = 0; r < 6; r++) begin
        for (int c = 0; c < 6; c++) row[c] = pick_sample();
        pending_rows.push_back(row);
      end
    end
    total_rows = pending_rows.size();

    // synchronous reset, then release
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (rows_accepted < total_rows) @(posedge clk);
    while (owed_rows.size() != 0) @(posedge clk);
    // wait on to catch any stray transaction
    repeat (16) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
